// ----- rtl/clpc_pkg.sv -----
// Shared constants and types for the common prefix length compare block.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package clpc_pkg;

	// Bytes per memory word and width of the length counters.
	localparam int WORD_BYTES = 8;
	localparam int LEN_BITS   = 32;

	localparam int WBITS = 8 * WORD_BYTES;
	// Byte lane index inside one word, also used for shift amounts and head.
	localparam int LAG_W = $clog2(WORD_BYTES);
	// Wide enough to hold a byte count from 0 to WORD_BYTES.
	localparam int CNT_W = $clog2(WORD_BYTES + 1);

	// Width of the port fields.
	localparam int OFF_W      = 3;
	localparam int PORT_LEN_W = 32;
	localparam int PORT_WORD_W = 64;

	// Depth of the queue between front and back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef logic [WBITS-1:0]    word_t;
	typedef logic [LEN_BITS-1:0] len_t;
	typedef logic [LAG_W-1:0]    lane_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	// One classified item as it travels from front to back.
	typedef struct packed {
		logic  start;     // first item of a comparison
		logic  zero_len;  // compare length zero, used only on a start item
		logic  a_lag;     // stream A is the lagging stream and gets realigned
		lane_t shift;     // realignment distance in bytes
		lane_t head;      // first byte lane that belongs to both strings
		len_t  clen;      // compare length, the smaller of the two lengths
		word_t word_a;
		word_t word_b;
	} item_t;

endpackage

`default_nettype wire

// ----- rtl/clpc_front.sv -----
// Front stage: accepts items, reduces offsets, and on a start item works out
// the compare length, the lagging stream, the shift and the head lane.
// Depends on clpc_pkg.
`default_nettype none

module clpc_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              start_req,
	input  wire logic [clpc_pkg::OFF_W-1:0]        offset_a,
	input  wire logic [clpc_pkg::OFF_W-1:0]        offset_b,
	input  wire logic [clpc_pkg::PORT_LEN_W-1:0]   len_a,
	input  wire logic [clpc_pkg::PORT_LEN_W-1:0]   len_b,
	input  wire logic [clpc_pkg::PORT_WORD_W-1:0]  word_a,
	input  wire logic [clpc_pkg::PORT_WORD_W-1:0]  word_b,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output clpc_pkg::item_t                        out_item
);

	logic            valid_s1;
	clpc_pkg::item_t item_s1;
	clpc_pkg::item_t item_d;
	clpc_pkg::lane_t oa;
	clpc_pkg::lane_t ob;
	clpc_pkg::len_t  la;
	clpc_pkg::len_t  lb;
	clpc_pkg::len_t  clen;

	// Offsets at or beyond the word size wrap around into the word.
	always_comb begin
		if (int'(offset_a) >= clpc_pkg::WORD_BYTES) begin
			oa = clpc_pkg::LAG_W'(int'(offset_a) - clpc_pkg::WORD_BYTES);
		end else begin
			oa = clpc_pkg::LAG_W'(offset_a);
		end
		if (int'(offset_b) >= clpc_pkg::WORD_BYTES) begin
			ob = clpc_pkg::LAG_W'(int'(offset_b) - clpc_pkg::WORD_BYTES);
		end else begin
			ob = clpc_pkg::LAG_W'(offset_b);
		end
	end

	assign la   = clpc_pkg::LEN_BITS'(len_a);
	assign lb   = clpc_pkg::LEN_BITS'(len_b);
	assign clen = (la < lb) ? la : lb;

	always_comb begin
		item_d.start    = start_req;
		item_d.zero_len = (clen == '0);
		item_d.a_lag    = (ob > oa);
		item_d.shift    = (ob > oa) ? (ob - oa) : (oa - ob);
		item_d.head     = (oa > ob) ? oa : ob;
		item_d.clen     = clen;
		item_d.word_a   = word_a[clpc_pkg::WBITS-1:0];
		item_d.word_b   = word_b[clpc_pkg::WBITS-1:0];
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

`default_nettype wire

// ----- rtl/clpc_queue.sv -----
// Short queue of classified items between the front and the back stage.
// Depends on clpc_pkg.
`default_nettype none

module clpc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire clpc_pkg::item_t push_item,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output clpc_pkg::item_t      pop_item
);

	clpc_pkg::item_t                 ent_q [clpc_pkg::Q_DEPTH];
	logic [clpc_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [clpc_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [clpc_pkg::Q_CNT_W-1:0]    fill_q;
	logic                            push;
	logic                            pop;

	assign push_ready = (fill_q != clpc_pkg::Q_CNT_W'(clpc_pkg::Q_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == clpc_pkg::Q_PTR_W'(clpc_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == clpc_pkg::Q_PTR_W'(clpc_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/clpc_back.sv -----
// Back stage: realigns the lagging stream, masks and compares one word pair,
// keeps the running count and holds the result in an output register.
// Depends on clpc_pkg.
`default_nettype none

module clpc_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire clpc_pkg::item_t                  in_item,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [clpc_pkg::PORT_LEN_W-1:0]       prefix_len,
	output logic                                  mismatch
);

	// Byte j of the result is byte j-lag of cur, or of prev one word back.
	function automatic clpc_pkg::word_t funnel(clpc_pkg::word_t cur,
			clpc_pkg::word_t prev, clpc_pkg::lane_t lag);
		logic [2*clpc_pkg::WBITS-1:0] cat;
		clpc_pkg::word_t              res;
		int                           k;
		cat = {cur, prev};
		res = '0;
		for (int j = 0; j < clpc_pkg::WORD_BYTES; j++) begin
			k = clpc_pkg::WORD_BYTES + j - int'(lag);
			res[8*j +: 8] = cat[8*k +: 8];
		end
		return res;
	endfunction

	logic            busy_q;
	logic            a_lag_q;
	clpc_pkg::lane_t shift_q;
	clpc_pkg::len_t  clen_q;
	clpc_pkg::len_t  count_q;
	clpc_pkg::len_t  rem_q;
	clpc_pkg::word_t held_a_q;
	clpc_pkg::word_t held_b_q;
	logic            out_valid_q;
	clpc_pkg::len_t  prefix_q;
	logic            mismatch_q;

	logic            take;
	logic            start;
	logic            active;
	logic            eff_a_lag;
	clpc_pkg::lane_t eff_shift;
	clpc_pkg::lane_t eff_head;
	clpc_pkg::len_t  eff_clen;
	clpc_pkg::len_t  eff_count;
	clpc_pkg::len_t  eff_rem;
	clpc_pkg::word_t prev_a;
	clpc_pkg::word_t prev_b;
	clpc_pkg::word_t a_al;
	clpc_pkg::word_t b_al;
	clpc_pkg::word_t diff;
	clpc_pkg::cnt_t  avail;
	clpc_pkg::cnt_t  n;
	logic            last;
	logic            found;
	clpc_pkg::lane_t p;
	clpc_pkg::len_t  hit_len;
	logic            emit;

	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;
	assign start    = in_item.start;
	assign active   = start || busy_q;

	// A start item uses its own setup; held words count as zero before it.
	always_comb begin
		eff_a_lag = start ? in_item.a_lag : a_lag_q;
		eff_shift = start ? in_item.shift : shift_q;
		eff_head  = start ? in_item.head : '0;
		eff_clen  = start ? in_item.clen : clen_q;
		eff_count = start ? '0 : count_q;
		eff_rem   = start ? in_item.clen : rem_q;
		prev_a    = start ? '0 : held_a_q;
		prev_b    = start ? '0 : held_b_q;
	end

	always_comb begin
		if (eff_a_lag) begin
			a_al = funnel(in_item.word_a, prev_a, eff_shift);
			b_al = in_item.word_b;
		end else begin
			a_al = in_item.word_a;
			b_al = funnel(in_item.word_b, prev_b, eff_shift);
		end
	end

	// Bytes compared on this item: from the head lane, up to the word end
	// or the remaining length, whichever comes first.
	always_comb begin
		avail = clpc_pkg::CNT_W'(clpc_pkg::WORD_BYTES) - clpc_pkg::CNT_W'(eff_head);
		last  = (eff_rem <= clpc_pkg::LEN_BITS'(avail));
		n     = (eff_rem < clpc_pkg::LEN_BITS'(avail)) ? clpc_pkg::CNT_W'(eff_rem) : avail;
	end

	always_comb begin
		for (int j = 0; j < clpc_pkg::WORD_BYTES; j++) begin
			if ((j >= int'(eff_head)) && (j < int'(eff_head) + int'(n))) begin
				diff[8*j +: 8] = a_al[8*j +: 8] ^ b_al[8*j +: 8];
			end else begin
				diff[8*j +: 8] = 8'h00;
			end
		end
	end

	// Lowest differing byte lane.
	always_comb begin
		found = 1'b0;
		p     = '0;
		for (int j = clpc_pkg::WORD_BYTES - 1; j >= 0; j--) begin
			if (diff[8*j +: 8] != 8'h00) begin
				found = 1'b1;
				p     = clpc_pkg::LAG_W'(j);
			end
		end
	end

	assign hit_len = eff_count + (clpc_pkg::LEN_BITS'(p) - clpc_pkg::LEN_BITS'(eff_head));
	assign emit    = (start && in_item.zero_len) || (active && (found || last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (start && in_item.zero_len) begin
					busy_q <= 1'b0;
				end else if (active) begin
					busy_q <= !(found || last);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (start && in_item.zero_len) begin
				held_a_q   <= in_item.word_a;
				held_b_q   <= in_item.word_b;
				prefix_q   <= '0;
				mismatch_q <= 1'b0;
			end else if (active) begin
				held_a_q <= in_item.word_a;
				held_b_q <= in_item.word_b;
				a_lag_q  <= eff_a_lag;
				shift_q  <= eff_shift;
				clen_q   <= eff_clen;
				count_q  <= eff_count + clpc_pkg::LEN_BITS'(n);
				rem_q    <= eff_rem - clpc_pkg::LEN_BITS'(n);
				if (found) begin
					prefix_q   <= hit_len;
					mismatch_q <= 1'b1;
				end else begin
					prefix_q   <= eff_clen;
					mismatch_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign prefix_len = clpc_pkg::PORT_LEN_W'(prefix_q);
	assign mismatch   = mismatch_q;

endmodule

`default_nettype wire

// ----- rtl/common_prefix_length_compare_top.sv -----
// Common prefix length compare, top level: front stage, queue and back stage.
// Path: the item that decides a result passes the front register, a queue entry and the output register.
// Throughput: one item per cycle while the output is not held off; the back stage compares one word pair
// per cycle and the output register frees itself in the cycle it is taken.
// Reset: arst_n clears the handshake state and the busy flag; the block is idle.
// Depends on clpc_pkg, clpc_front, clpc_queue and clpc_back.
`default_nettype none

module common_prefix_length_compare_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              start_req,
	input  wire logic [clpc_pkg::OFF_W-1:0]        offset_a,
	input  wire logic [clpc_pkg::OFF_W-1:0]        offset_b,
	input  wire logic [clpc_pkg::PORT_LEN_W-1:0]   len_a,
	input  wire logic [clpc_pkg::PORT_LEN_W-1:0]   len_b,
	input  wire logic [clpc_pkg::PORT_WORD_W-1:0]  word_a,
	input  wire logic [clpc_pkg::PORT_WORD_W-1:0]  word_b,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [clpc_pkg::PORT_LEN_W-1:0]        prefix_len,
	output logic                                   mismatch
);

	// The front stage registers every item and, for a start item, works out
	// the compare length, which stream lags and by how many bytes, and the
	// first byte lane that holds string bytes of both streams. Items that
	// arrive while no comparison runs still pass through; the back stage
	// owns the busy state and drops them there.
	logic            fr_valid;
	logic            fr_ready;
	clpc_pkg::item_t fr_item;

	// The queue lets the front keep accepting while the back stage waits on
	// a full output register, and the reverse.
	logic            q_valid;
	logic            q_ready;
	clpc_pkg::item_t q_item;

	clpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.start_req (start_req),
		.offset_a  (offset_a),
		.offset_b  (offset_b),
		.len_a     (len_a),
		.len_b     (len_b),
		.word_a    (word_a),
		.word_b    (word_b),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_item  (fr_item)
	);

	clpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// The back stage realigns the lagging stream with a funnel shift of its
	// held and current words, masks head and tail bytes, finds the first
	// differing byte and keeps the running count. It emits at most one item
	// per comparison, then ignores items until the next start.
	clpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.in_item    (q_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prefix_len (prefix_len),
		.mismatch   (mismatch)
	);

endmodule

`default_nettype wire

// ----- test/clpc_prefix_checker.sv -----
// Prefix compare checker: watches the item and result channels of the block,
// predicts every result from the accepted items and checks it on arrival.
// Depends on clpc_pkg for the word and length types and the port widths.

module clpc_prefix_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                start_req,
	input  logic [clpc_pkg::OFF_W-1:0]          offset_a,
	input  logic [clpc_pkg::OFF_W-1:0]          offset_b,
	input  logic [clpc_pkg::PORT_LEN_W-1:0]     len_a,
	input  logic [clpc_pkg::PORT_LEN_W-1:0]     len_b,
	input  logic [clpc_pkg::PORT_WORD_W-1:0]    word_a,
	input  logic [clpc_pkg::PORT_WORD_W-1:0]    word_b,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [clpc_pkg::PORT_LEN_W-1:0]     prefix_len,
	input  logic                                mismatch,
	output int                                  fail_count,
	output int                                  pending_count,
	output int                                  checked_count
);
	import clpc_pkg::*;

	typedef struct packed {
		len_t prefix;
		logic differs;
	} prefix_result_t;

	// Private copy of the block's comparison state.
	word_t          prev_a = '0;
	word_t          prev_b = '0;
	len_t           matched_bytes = '0;
	len_t           limit_bytes = '0;
	logic [LAG_W:0] lane_lag = '0;
	logic           comparing = 1'b0;

	prefix_result_t expected_q[$];
	prefix_result_t oldest;
	prefix_result_t fresh;
	logic           fresh_valid;
	int             errors = 0;
	int             checked = 0;

	// Lane j of the result takes lane j-lag of the current word, or lane
	// WORD_BYTES+j-lag of the previous word when j is below the lag.
	function automatic word_t realign(word_t cur, word_t prev, int lag);
		if (lag == 0)
			return cur;
		return (cur << (8 * lag)) | (prev >> (WBITS - 8 * lag));
	endfunction

	task automatic predict_prefix(input logic st, input logic [OFF_W-1:0] off_a, off_b,
			input len_t la, lb, input word_t wa, wb,
			output logic emits, output prefix_result_t res);
		word_t a_al, b_al, diff, lane_mask;
		len_t  remaining;
		int    oa, ob, head, take, pos, j;
		logic  live;
		emits = 1'b0;
		res = '0;
		head = 0;
		live = comparing;
		if (st) begin
			oa = off_a % WORD_BYTES;
			ob = off_b % WORD_BYTES;
			limit_bytes = (la < lb) ? la : lb;
			matched_bytes = '0;
			lane_lag = (LAG_W + 1)'(ob + WORD_BYTES - oa);
			prev_a = '0;
			prev_b = '0;
			head = (oa > ob) ? oa : ob;
			live = (limit_bytes != '0);
			if (!live) begin
				// Nothing to compare: the answer is zero at once.
				prev_a = wa;
				prev_b = wb;
				emits = 1'b1;
			end
			comparing = live;
		end
		if (live) begin
			// The stream with the smaller start offset lags and is shifted up.
			if (int'(lane_lag) > WORD_BYTES) begin
				a_al = realign(wa, prev_a, int'(lane_lag) - WORD_BYTES);
				b_al = wb;
			end else begin
				a_al = wa;
				b_al = realign(wb, prev_b, WORD_BYTES - int'(lane_lag));
			end
			prev_a = wa;
			prev_b = wb;
			remaining = limit_bytes - matched_bytes;
			take = WORD_BYTES - head;
			if (remaining < take)
				take = remaining;
			lane_mask = '0;
			for (j = head; j < head + take; j++)
				lane_mask[8 * j +: 8] = 8'hFF;
			diff = (a_al ^ b_al) & lane_mask;
			if (diff != '0) begin
				pos = 0;
				while (diff[8 * pos +: 8] == 8'h00)
					pos++;
				res.prefix = matched_bytes + pos - head;
				res.differs = 1'b1;
				emits = 1'b1;
				comparing = 1'b0;
			end else begin
				matched_bytes = matched_bytes + take;
				if (matched_bytes >= limit_bytes) begin
					res.prefix = limit_bytes;
					res.differs = 1'b0;
					emits = 1'b1;
					comparing = 1'b0;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a = '0;
			prev_b = '0;
			matched_bytes = '0;
			limit_bytes = '0;
			lane_lag = '0;
			comparing = 1'b0;
			expected_q.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 30)
						$display("%0t: result with none expected, got prefix_len %0d mismatch %0b",
							$time, prefix_len, mismatch);
				end else begin
					oldest = expected_q.pop_front();
					checked++;
					if (prefix_len !== oldest.prefix) begin
						errors++;
						if (errors <= 30)
							$display("%0t: prefix_len expected %0d, got %0d",
								$time, oldest.prefix, prefix_len);
					end
					if (mismatch !== oldest.differs) begin
						errors++;
						if (errors <= 30)
							$display("%0t: mismatch expected %0b, got %0b",
								$time, oldest.differs, mismatch);
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_prefix(start_req, offset_a, offset_b, len_a, len_b, word_a, word_b,
					fresh_valid, fresh);
				if (fresh_valid)
					expected_q.push_back(fresh);
			end
			pending_count <= expected_q.size();
		end
		fail_count <= errors;
		checked_count <= checked;
	end

endmodule

// ----- test/tb.sv -----
// Testbench top for the common prefix length compare block: clock, reset,
// item and result stimulus, a long output hold-off and the final verdict.
// Depends on clpc_pkg, common_prefix_length_compare_top and clpc_prefix_checker.

module tb;
	import clpc_pkg::*;

	// Far above the slowest legal run: each item and each result after its longest
	// random gap, plus one hold-off.
	localparam int LIMIT_CYCLES = 400000;
	localparam int TARGET_ITEMS = 1450;
	localparam int STREAM_WORDS = 64;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 10;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   start_req = 1'b0;
	logic [OFF_W-1:0]       offset_a = '0;
	logic [OFF_W-1:0]       offset_b = '0;
	logic [PORT_LEN_W-1:0]  len_a = '0;
	logic [PORT_LEN_W-1:0]  len_b = '0;
	logic [PORT_WORD_W-1:0] word_a = '0;
	logic [PORT_WORD_W-1:0] word_b = '0;
	logic                   out_ready = 1'b0;
	logic                   in_ready;
	logic                   out_valid;
	logic [PORT_LEN_W-1:0]  prefix_len;
	logic                   mismatch;

	int fail_count;
	int pending_count;
	int checked_count;
	int cycle_count = 0;

	// Stimulus bookkeeping, also used for the closing summary.
	int sent_items = 0;
	int comparisons = 0;
	int zero_runs = 0;
	int cut_runs = 0;

	// When set, the sender or the receiver stops idling for a while.
	logic sender_calm = 1'b0;
	logic receiver_calm = 1'b0;
	// Raised once by the sender to ask the receiver for its long hold-off.
	logic hold_request = 1'b0;
	logic hold_done = 1'b0;

	// Memory images of the two strings, one aligned word per entry.
	word_t stream_a[STREAM_WORDS];
	word_t stream_b[STREAM_WORDS];

	always #6 clk = ~clk;

	common_prefix_length_compare_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_req  (start_req),
		.offset_a   (offset_a),
		.offset_b   (offset_b),
		.len_a      (len_a),
		.len_b      (len_b),
		.word_a     (word_a),
		.word_b     (word_b),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prefix_len (prefix_len),
		.mismatch   (mismatch)
	);

	clpc_prefix_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_req     (start_req),
		.offset_a      (offset_a),
		.offset_b      (offset_b),
		.len_a         (len_a),
		.len_b         (len_b),
		.word_a        (word_a),
		.word_b        (word_b),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.prefix_len    (prefix_len),
		.mismatch      (mismatch),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	function automatic word_t random_word();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly short strings, some longer ones, a few full 32-bit lengths
	// and a few empty ones.
	function automatic len_t pick_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return '0;
		if (roll < 10)
			return $urandom();
		if (roll < 22)
			return $urandom_range(41, 300);
		return $urandom_range(1, 40);
	endfunction

	// Offers one item after a random idle gap and returns at the clock edge
	// where it is taken. Valid is only dropped when a gap follows, so a
	// back-to-back item never sees valid fall and rise in the same step.
	task automatic offer_item(input logic st, input logic [OFF_W-1:0] oa, ob,
			input len_t la, lb, input word_t wa, wb);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		start_req <= st;
		offset_a  <= oa;
		offset_b  <= ob;
		len_a     <= la;
		len_b     <= lb;
		word_a    <= wa;
		word_b    <= wb;
		do @(posedge clk); while (!in_ready);
	endtask

	// Builds two memory images whose strings agree up to byte stop_at and
	// differ there; a stop_at at or past the compare length gives a full
	// match. Bytes outside the strings stay random, so the masking of head
	// and tail lanes is exercised on every comparison. Sends just enough
	// word pairs to reach the deciding byte, or only keep of them when keep
	// is smaller, which leaves the block busy for the next start.
	task automatic run_comparison(input int oa, ob, input len_t la, lb,
			input int stop_at, input int keep);
		len_t       clen;
		int         head, span, count, i, w;
		logic [7:0] ch;
		clen = (la < lb) ? la : lb;
		head = (oa > ob) ? oa : ob;
		span = (stop_at < clen) ? stop_at + 1 : clen;
		count = (head + span + WORD_BYTES - 1) / WORD_BYTES;
		if (count == 0)
			count = 1;
		for (w = 0; w < count; w++) begin
			stream_a[w] = random_word();
			stream_b[w] = random_word();
		end
		for (i = 0; i < span; i++) begin
			ch = $urandom_range(0, 255);
			stream_a[(oa + i) / WORD_BYTES][8 * ((oa + i) % WORD_BYTES) +: 8] = ch;
			if (i == stop_at)
				ch = ch ^ $urandom_range(1, 255);
			stream_b[(ob + i) / WORD_BYTES][8 * ((ob + i) % WORD_BYTES) +: 8] = ch;
		end
		if (clen == '0)
			zero_runs++;
		if (keep > 0 && keep < count) begin
			count = keep;
			cut_runs++;
		end
		comparisons++;
		// Fields other than the words only count on the start item, so the
		// later items carry random values there.
		for (w = 0; w < count; w++) begin
			offer_item(w == 0,
				(w == 0) ? oa : $urandom_range(0, 7),
				(w == 0) ? ob : $urandom_range(0, 7),
				(w == 0) ? la : $urandom(),
				(w == 0) ? lb : $urandom(),
				stream_a[w], stream_b[w]);
			sent_items++;
		end
	endtask

	// Result side: a random stall before each result, no stalls while the
	// calm flag is up, and one long hold-off when the sender asks for it.
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			if (hold_request && !hold_done) begin
				stall = HOLD_CYCLES;
				hold_done = 1'b1;
			end else begin
				stall = receiver_calm ? 0 : $urandom_range(0, 14);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Guards against a hang: the run ends here if the limit is reached.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles, %0d results still outstanding.",
			cycle_count, pending_count);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int   roll, oa, ob, stop, keep, n;
		len_t la, lb, clen;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An item while idle, with every field at an extreme,
		// must be dropped without a result.
		offer_item(1'b0, 3'd7, 3'd7, '1, '1, '1, '0);
		// Empty string A, then both strings empty: answer zero at once.
		run_comparison(2, 5, 0, 10, 0, 0);
		run_comparison(7, 7, 0, 0, 0, 0);
		// Full match inside one aligned word.
		run_comparison(0, 0, 8, 8, 8, 0);
		// B lags by the most lanes; A lags by the most lanes and differs
		// at its very first byte.
		run_comparison(7, 0, 16, 20, 16, 0);
		run_comparison(0, 7, 12, 12, 0, 0);
		// Largest lengths: only a difference can end the comparison.
		run_comparison(3, 5, '1, '1, 9, 0);
		// One huge length against a short one; B words past its end are junk.
		run_comparison(4, 1, '1, 5, 5, 0);
		// A comparison left unfinished and then replaced by a new start,
		// which differs in its last byte.
		run_comparison(1, 6, 40, 40, 40, 1);
		run_comparison(6, 2, 23, 30, 22, 0);
		// All-ones against all-ones and all-zeros words, then an item after
		// the result that must be ignored.
		offer_item(1'b1, 3'd0, 3'd0, 8, 8, '1, '1);
		offer_item(1'b1, 3'd0, 3'd0, 8, 8, '1, '0);
		offer_item(1'b0, 3'd0, 3'd0, '0, '0, '0, '0);

		// Random part: mostly well-formed comparisons with random content,
		// with noise items, empty strings and cut-short comparisons mixed in.
		while (sent_items < TARGET_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				sender_calm = ($urandom_range(0, 3) == 0);
				receiver_calm = ($urandom_range(0, 3) == 0);
			end
			// Once, halfway through: the receiver holds off while a burst of
			// empty-string starts, each one a result, fills the block until
			// it stops taking items.
			if (!hold_request && sent_items > TARGET_ITEMS / 2) begin
				hold_request = 1'b1;
				sender_calm = 1'b1;
				repeat (16)
					run_comparison($urandom_range(0, 7), $urandom_range(0, 7),
						0, $urandom(), 0, 0);
				sender_calm = 1'b0;
			end
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				// Noise: taken up by the block only if a cut-short
				// comparison is still running, ignored otherwise.
				n = $urandom_range(1, 3);
				repeat (n)
					offer_item(1'b0, $urandom_range(0, 7), $urandom_range(0, 7),
						$urandom(), $urandom(), random_word(), random_word());
			end else if (roll < 14) begin
				run_comparison($urandom_range(0, 7), $urandom_range(0, 7),
					($urandom_range(0, 1) == 0) ? '0 : $urandom(), '0, 0, 0);
			end else begin
				oa = $urandom_range(0, 7);
				ob = $urandom_range(0, 7);
				la = pick_length();
				lb = pick_length();
				clen = (la < lb) ? la : lb;
				if (clen == '0)
					stop = 0;
				else if (clen <= 300 && $urandom_range(0, 2) == 0)
					stop = clen;
				else
					stop = $urandom_range(0, (clen > 300) ? 300 : clen - 1);
				keep = (roll < 24) ? $urandom_range(1, 3) : 0;
				run_comparison(oa, ob, la, lb, stop, keep);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		// A result passes the front register, the queue and the output register after its item;
		// give any stray result time to show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d comparisons over %0d counted items.",
			checked_count, comparisons, sent_items);
		$display("Included %0d empty-string starts, %0d cut-short runs and one long output stall.",
			zero_runs, cut_runs);
		if (fail_count == 0 && pending_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/clpc_pkg.sv
rtl/clpc_front.sv
rtl/clpc_queue.sv
rtl/clpc_back.sv
rtl/common_prefix_length_compare_top.sv
test/clpc_prefix_checker.sv
test/tb.sv
